>>> hdl/fdwd_pkg.sv
// ----------------------------------------------------------------------------
// fdwd_pkg: shared types and constants for the damped feedback delay
// Widths, register indexes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package fdwd_pkg;

  localparam int unsigned MAX_DELAY_DEF = 131072;
  localparam int unsigned CHANNELS_DEF  = 2;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = 26;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned MIX_W     = 17;
  localparam int unsigned COEF_W    = 20;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned CFG_W     = 26;
  localparam int unsigned CFG_IDX_W = 3;

  // shared multiplier and accumulator
  localparam int unsigned MA_W   = 21;
  localparam int unsigned MB_W   = 17;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned ACC_W  = 40;

  localparam logic [GAIN_W-1:0]  GAIN_MAX   = 16'd62259;
  localparam logic [MIX_W-1:0]   MIX_ONE    = 17'd65536;
  localparam logic [DELAY_W-1:0] DELAY_RST  = 26'd3072000;
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 16'd19661;
  localparam logic [MIX_W-1:0]   MIX_RST    = 17'd19661;

  localparam logic signed [ACC_W-1:0] S16_MAX = {{(ACC_W-16){1'b0}}, 16'h7fff};
  localparam logic signed [ACC_W-1:0] S16_MIN = {{(ACC_W-16){1'b1}}, 16'h8000};
  localparam logic signed [ACC_W-1:0] S32_MAX = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [ACC_W-1:0] S32_MIN = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY, REG_GAIN, REG_MIX, REG_B0, REG_B1, REG_B2, REG_A1, REG_A2
  } reg_idx_e;

  // multiplier operand A
  typedef enum logic [3:0] {
    MA_FRAC, MA_ONEMIX, MA_MIX, MA_GAIN, MA_B0, MA_B1, MA_B2, MA_A1, MA_A2
  } ma_e;

  // multiplier operand B
  typedef enum logic [1:0] {
    MB_DIFF, MB_DL, MB_Y, MB_X
  } mb_e;

  // accumulator base
  typedef enum logic [2:0] {
    AB_HOLD, AB_ZERO, AB_SELF, AB_V1, AB_S1, AB_S2
  } ab_e;

  // writeback target
  typedef enum logic [3:0] {
    WB_NONE, WB_V1, WB_V2, WB_DL, WB_RES, WB_RESX, WB_Y, WB_S1, WB_S2, WB_STORE
  } wb_e;

  typedef enum logic [1:0] {
    RD_NONE, RD_TAP1, RD_TAP2
  } rd_e;

  // sequencer branch condition
  typedef enum logic [2:0] {
    JC_NEXT, JC_WAIT_IN, JC_BYP, JC_WAIT_OUT, JC_JUMP
  } jc_e;

  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE   = 5'd0;
  localparam step_t ST_RD1    = 5'd1;
  localparam step_t ST_RD2    = 5'd2;
  localparam step_t ST_V2     = 5'd3;
  localparam step_t ST_INTERP = 5'd4;
  localparam step_t ST_ACC_DL = 5'd5;
  localparam step_t ST_DL     = 5'd6;
  localparam step_t ST_MIXA   = 5'd7;
  localparam step_t ST_MIXB   = 5'd8;
  localparam step_t ST_Y0     = 5'd9;
  localparam step_t ST_Y      = 5'd10;
  localparam step_t ST_FB1    = 5'd11;
  localparam step_t ST_S1A    = 5'd12;
  localparam step_t ST_S1     = 5'd13;
  localparam step_t ST_S2A    = 5'd14;
  localparam step_t ST_S2     = 5'd15;
  localparam step_t ST_STORE  = 5'd16;
  localparam step_t ST_OUT    = 5'd17;
  localparam step_t ST_BYP    = 5'd18;

  typedef struct packed {
    jc_e   cond;
    step_t target;
    rd_e   rd;
    ma_e   ma;
    mb_e   mb;
    ab_e   ab;
    logic  sub;
    wb_e   wb;
    logic  emit;
  } uc_t;

  // Program. Product is registered and lands in the step after its operands are selected;
  // a writeback reads the accumulator left by the previous step.
  function automatic uc_t uc_rom(input step_t s);
    uc_t w;
    w.cond   = JC_NEXT;
    w.target = ST_IDLE;
    w.rd     = RD_NONE;
    w.ma     = MA_FRAC;
    w.mb     = MB_DIFF;
    w.ab     = AB_HOLD;
    w.sub    = 1'b0;
    w.wb     = WB_NONE;
    w.emit   = 1'b0;
    unique case (s)
      ST_IDLE:   w.cond = JC_WAIT_IN;
      ST_RD1: begin
        w.rd = RD_TAP1; w.cond = JC_BYP; w.target = ST_BYP;
      end
      ST_RD2: begin
        w.rd = RD_TAP2; w.wb = WB_V1;
      end
      ST_V2:     w.wb = WB_V2;
      ST_INTERP: begin
        w.ma = MA_FRAC; w.mb = MB_DIFF;
      end
      ST_ACC_DL: w.ab = AB_V1;
      ST_DL: begin
        w.wb = WB_DL; w.ma = MA_ONEMIX; w.mb = MB_X;
      end
      ST_MIXA: begin
        w.ab = AB_ZERO; w.ma = MA_MIX; w.mb = MB_DL;
      end
      ST_MIXB: begin
        w.ab = AB_SELF; w.ma = MA_B0; w.mb = MB_DL;
      end
      ST_Y0: begin
        w.wb = WB_RES; w.ab = AB_S1; w.ma = MA_B1; w.mb = MB_DL;
      end
      ST_Y: begin
        w.wb = WB_Y; w.ab = AB_S2;
      end
      ST_FB1: begin
        w.ma = MA_A1; w.mb = MB_Y;
      end
      ST_S1A: begin
        w.ab = AB_SELF; w.sub = 1'b1; w.ma = MA_B2; w.mb = MB_DL;
      end
      ST_S1: begin
        w.wb = WB_S1; w.ab = AB_ZERO; w.ma = MA_A2; w.mb = MB_Y;
      end
      ST_S2A: begin
        w.ab = AB_SELF; w.sub = 1'b1; w.ma = MA_GAIN; w.mb = MB_Y;
      end
      ST_S2: begin
        w.wb = WB_S2; w.ab = AB_ZERO;
      end
      ST_STORE:  w.wb = WB_STORE;
      ST_OUT: begin
        w.emit = 1'b1; w.cond = JC_WAIT_OUT; w.target = ST_IDLE;
      end
      ST_BYP: begin
        w.wb = WB_RESX; w.cond = JC_JUMP; w.target = ST_OUT;
      end
      default: begin
        w.cond = JC_JUMP; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > S16_MAX) c = S16_MAX;
    else if (v < S16_MIN) c = S16_MIN;
    else c = v;
    return c[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > S32_MAX) c = S32_MAX;
    else if (v < S32_MIN) c = S32_MIN;
    else c = v;
    return c[STATE_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/fdwd_seq.sv
// ----------------------------------------------------------------------------
// fdwd_seq: microcode sequencer
// Step counter, control ROM and branch logic; drives the datapath word.
// ----------------------------------------------------------------------------
`default_nettype none

module fdwd_seq
  import fdwd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,     // input transaction taken
  input  wire logic byp_i,       // latched bypass for current item
  input  wire logic out_free_i,  // result register can load
  output uc_t       uc_o
);

  step_t step_q, step_d, step_inc;
  uc_t   uc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    uc       = uc_rom(step_q);
    step_inc = step_q + STEP_W'(1);
    unique case (uc.cond)
      JC_NEXT:     step_d = step_inc;
      JC_WAIT_IN:  step_d = start_i ? step_inc : step_q;
      JC_BYP:      step_d = byp_i ? uc.target : step_inc;
      JC_WAIT_OUT: step_d = out_free_i ? uc.target : step_q;
      JC_JUMP:     step_d = uc.target;
      default:     step_d = ST_IDLE;
    endcase
  end

  assign uc_o = uc;

endmodule

`default_nettype wire

>>> hdl/feedback_delay_with_damping.sv
// ----------------------------------------------------------------------------
// feedback_delay_with_damping: per-channel feedback echo with biquad damping
// Fractional-delay echo store, low-pass in the feedback path, wet/dry mix.
// ----------------------------------------------------------------------------
// One sample transaction is processed at a time by a microcoded sequencer
// driving a single shared 21x17 multiplier and a 40-bit accumulator. A normal
// item makes two reads from the single read port of the echo store, then nine
// multiplies through the one multiplier, plus writebacks, before its result is
// offered; a bypassed item, or one for an absent channel, skips the multiplies
// and the echo store write and offers its input sample as the result. The next
// input is taken once the result has been loaded into the output register, so
// a slow consumer only stalls the block after one result is waiting.
// The echo store is not swept after reset: a per-channel fill count records
// how many samples have been written, and any tap older than that reads as
// zero, so the block is usable straight out of reset. Configuration is
// written through a plain write port and must only change while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_delay_with_damping
  import fdwd_pkg::*;
#(
  parameter int unsigned MAX_DELAY = MAX_DELAY_DEF,  // samples per channel
  parameter int unsigned CHANNELS  = CHANNELS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,

  // sample input
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,   // [15:0] in_sample
  input  wire logic [1:0]           s_axis_tuser,   // [0] chan, [1] bypass

  // result output
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [15:0]          m_axis_tdata,   // [15:0] out_sample
  output      logic [0:0]           m_axis_tuser    // [0] out_chan
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW    = $clog2(MAX_DELAY);          // write position
  localparam int unsigned FW    = $clog2(MAX_DELAY + 1);      // fill count
  localparam int unsigned DW    = $clog2(MAX_DELAY + 2);      // tap distance
  localparam int unsigned TW    = $clog2(3 * MAX_DELAY);      // wrap arithmetic
  localparam int unsigned DEPTH = CHANNELS * MAX_DELAY;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = DELAY_W - FRAC_W;           // integer delay

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [DELAY_W-1:0] delay_q;
  logic        [GAIN_W-1:0]  gain_q;
  logic        [MIX_W-1:0]   mix_q;
  logic signed [COEF_W-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;

  // --------------------------------------------------------------------------
  // State and datapath registers
  // --------------------------------------------------------------------------
  logic        [PW-1:0]       wp_q   [CHANNELS];
  logic        [FW-1:0]       fill_q [CHANNELS];
  logic signed [STATE_W-1:0]  s1_q   [CHANNELS];
  logic signed [STATE_W-1:0]  s2_q   [CHANNELS];

  logic signed [SAMPLE_W-1:0] mem_q  [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rd_ok_q;
  logic signed [SAMPLE_W-1:0] store_val;

  logic signed [SAMPLE_W-1:0] x_q, v1_q, v2_q, dl_q, y_q, res_q;
  logic                       chan_q, byp_q;
  logic        [CW-1:0]       ch_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d, acc_base;

  logic                       m_valid_q, m_valid_d;
  logic signed [SAMPLE_W-1:0] m_data_q;
  logic                       m_chan_q;

  uc_t uc;
  logic start, byp_in, out_free, out_ld, store_we, rd_en;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_axis_tready = (uc.cond == JC_WAIT_IN);
  assign start         = s_axis_tvalid & s_axis_tready;
  assign byp_in        = s_axis_tuser[1] | (32'(s_axis_tuser[0]) >= 32'(CHANNELS));
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign out_ld        = uc.emit & out_free;
  assign store_we      = (uc.wb == WB_STORE);
  assign rd_en         = (uc.rd != RD_NONE);

  fdwd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .byp_i      (byp_q),
    .out_free_i (out_free),
    .uc_o       (uc)
  );

  // --------------------------------------------------------------------------
  // Delay decode: clamp to one sample .. MAX_DELAY samples. At either end the
  // fraction is dropped so the second tap carries no weight.
  // --------------------------------------------------------------------------
  logic [IW-1:0]     dly_int;
  logic [FRAC_W-1:0] dly_frac, frac;
  logic [DW-1:0]     dist1, dist2, tap_dist;

  assign dly_int  = delay_q[DELAY_W-1:FRAC_W];
  assign dly_frac = delay_q[FRAC_W-1:0];

  always_comb begin
    if (dly_int == '0) begin
      dist1 = DW'(1);
      frac  = '0;
    end else if ((32'(dly_int) > 32'(MAX_DELAY)) ||
                 ((32'(dly_int) == 32'(MAX_DELAY)) && (dly_frac != '0))) begin
      dist1 = DW'(MAX_DELAY);
      frac  = '0;
    end else begin
      dist1 = DW'(dly_int);
      frac  = dly_frac;
    end
  end

  assign dist2    = dist1 + DW'(1);
  assign tap_dist = (uc.rd == RD_TAP2) ? dist2 : dist1;

  // --------------------------------------------------------------------------
  // Store addressing: slot = (wp - dist) mod MAX_DELAY, offset by channel
  // --------------------------------------------------------------------------
  logic [TW-1:0] wrap_t;
  logic [PW-1:0] tap_idx;
  logic [AW-1:0] ch_base, rd_addr, wr_addr;
  logic          tap_ok;

  always_comb begin
    wrap_t = TW'(wp_q[ch_q]) + TW'(2 * MAX_DELAY) - TW'(tap_dist);
    if (wrap_t >= TW'(2 * MAX_DELAY)) begin
      tap_idx = PW'(wrap_t - TW'(2 * MAX_DELAY));
    end else if (wrap_t >= TW'(MAX_DELAY)) begin
      tap_idx = PW'(wrap_t - TW'(MAX_DELAY));
    end else begin
      tap_idx = PW'(wrap_t);
    end
  end

  assign ch_base = AW'(ch_q) * AW'(MAX_DELAY);
  assign rd_addr = ch_base + AW'(tap_idx);
  assign wr_addr = ch_base + AW'(wp_q[ch_q]);
  // slots older than the fill count were never written and read as zero
  assign tap_ok  = (32'(tap_dist) <= 32'(fill_q[ch_q]));

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      mem_q[wr_addr] <= store_val;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      rd_ok_q <= tap_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier and accumulator
  // --------------------------------------------------------------------------
  logic        [GAIN_W-1:0] gain_c;
  logic        [MIX_W-1:0]  mix_c;
  logic signed [MA_W-1:0]   op_a;
  logic signed [MB_W-1:0]   op_b;

  assign gain_c = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
  assign mix_c  = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;

  always_comb begin
    case (uc.ma)
      MA_FRAC:   op_a = MA_W'(frac);
      MA_ONEMIX: op_a = MA_W'(MIX_ONE - mix_c);
      MA_MIX:    op_a = MA_W'(mix_c);
      MA_GAIN:   op_a = MA_W'(gain_c);
      MA_B0:     op_a = MA_W'(b0_q);
      MA_B1:     op_a = MA_W'(b1_q);
      MA_B2:     op_a = MA_W'(b2_q);
      MA_A1:     op_a = MA_W'(a1_q);
      MA_A2:     op_a = MA_W'(a2_q);
      default:   op_a = '0;
    endcase
    case (uc.mb)
      MB_DIFF: op_b = MB_W'(v2_q) - MB_W'(v1_q);
      MB_DL:   op_b = MB_W'(dl_q);
      MB_Y:    op_b = MB_W'(y_q);
      MB_X:    op_b = MB_W'(x_q);
      default: op_b = '0;
    endcase
    case (uc.ab)
      AB_ZERO: acc_base = '0;
      AB_SELF: acc_base = acc_q;
      AB_V1:   acc_base = ACC_W'(v1_q) <<< FRAC_W;
      AB_S1:   acc_base = ACC_W'(s1_q[ch_q]);
      AB_S2:   acc_base = ACC_W'(s2_q[ch_q]);
      default: acc_base = acc_q;
    endcase
    acc_d = uc.sub ? (acc_base - ACC_W'(prod_q)) : (acc_base + ACC_W'(prod_q));
  end

  // rounding shifts: floor((acc + half) / 2^n)
  logic signed [ACC_W-1:0]    rnd8, rnd16;

  assign rnd8      = (acc_q + ACC_W'(128)) >>> FRAC_W;
  assign rnd16     = (acc_q + ACC_W'(32768)) >>> 16;
  assign store_val = sat16(ACC_W'(x_q) + rnd16);

  // --------------------------------------------------------------------------
  // Datapath registers (no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q    <= s_axis_tdata[SAMPLE_W-1:0];
      chan_q <= s_axis_tuser[0];
      ch_q   <= CW'(s_axis_tuser[0]);
      byp_q  <= byp_in;
    end
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
    if (uc.ab != AB_HOLD) begin
      acc_q <= acc_d;
    end
    case (uc.wb)
      WB_V1:   v1_q  <= rd_ok_q ? rdata_q : '0;
      WB_V2:   v2_q  <= rd_ok_q ? rdata_q : '0;
      WB_DL:   dl_q  <= rnd8[SAMPLE_W-1:0];
      WB_RES:  res_q <= sat16(rnd16);
      WB_RESX: res_q <= x_q;
      WB_Y:    y_q   <= sat16(rnd16);
      default: ;
    endcase
    if (out_ld) begin
      m_data_q <= res_q;
      m_chan_q <= chan_q;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration, channel state and output valid
  // --------------------------------------------------------------------------
  assign m_valid_d = out_ld | (m_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= DELAY_RST;
      gain_q    <= GAIN_RST;
      mix_q     <= MIX_RST;
      b0_q      <= '0;
      b1_q      <= '0;
      b2_q      <= '0;
      a1_q      <= '0;
      a2_q      <= '0;
      m_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]   <= '0;
        fill_q[c] <= '0;
        s1_q[c]   <= '0;
        s2_q[c]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_DELAY: delay_q <= cfg_wdata_i[DELAY_W-1:0];
          REG_GAIN:  gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          REG_MIX:   mix_q   <= cfg_wdata_i[MIX_W-1:0];
          REG_B0:    b0_q    <= cfg_wdata_i[COEF_W-1:0];
          REG_B1:    b1_q    <= cfg_wdata_i[COEF_W-1:0];
          REG_B2:    b2_q    <= cfg_wdata_i[COEF_W-1:0];
          REG_A1:    a1_q    <= cfg_wdata_i[COEF_W-1:0];
          REG_A2:    a2_q    <= cfg_wdata_i[COEF_W-1:0];
        endcase
      end
      if (uc.wb == WB_S1) begin
        s1_q[ch_q] <= sat32(acc_q);
      end
      if (uc.wb == WB_S2) begin
        s2_q[ch_q] <= sat32(acc_q);
      end
      if (store_we) begin
        wp_q[ch_q] <= (32'(wp_q[ch_q]) == 32'(MAX_DELAY - 1)) ? '0
                                                             : wp_q[ch_q] + PW'(1);
        if (32'(fill_q[ch_q]) != 32'(MAX_DELAY)) begin
          fill_q[ch_q] <= fill_q[ch_q] + FW'(1);
        end
      end
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_chan_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // bypassed items never write the echo store
  a_store_not_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> !byp_q)
    else $error("echo store written for a bypassed transaction");

  // busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !s_axis_tready)
    else $error("input ready while a transaction is in flight");

  // write position and fill count stay in range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> ((32'(wp_q[ch_q]) < 32'(MAX_DELAY)) &&
                  (32'(fill_q[ch_q]) <= 32'(MAX_DELAY))))
    else $error("write position or fill count out of range");

  // a result appears only from the output step of the program
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(uc.emit))
    else $error("result valid without an output step");
`endif

endmodule

`default_nettype wire
